// File: hdl/idwt_pkg.sv
// Package for the inverse 5/3 horizontal line block: item types and result bundle.
// No dependencies; used by every module under hdl.
`timescale 1ns / 1ps

package idwt_pkg;

  localparam int unsigned SampleW = 32;
  localparam int unsigned HighW   = 16;
  localparam int unsigned ShiftW  = 5;
  localparam int unsigned MaxRes  = 3;
  localparam int unsigned CountW  = 2;

  // Configuration register indexes.
  localparam logic [1:0] CfgHfShift   = 2'd0;
  localparam logic [1:0] CfgLfPrescale = 2'd1;

  typedef struct packed {
    logic signed [SampleW-1:0] low_sample;
    logic signed [HighW-1:0]   high_sample;
    logic                      high_present;
    logic                      line_end;
  } in_item_t;

  typedef struct packed {
    logic signed [SampleW-1:0] pixel_value;
    logic                      line_done;
  } out_item_t;

  // Results that one item produces, entry 0 first in line order.
  typedef struct packed {
    out_item_t [MaxRes-1:0] res;
    logic [CountW-1:0]      count;
  } res_set_t;

endpackage

// File: hdl/idwt53_horizontal_line.sv
// Top level of the inverse 5/3 horizontal line block.
// Depends on idwt_pkg, idwt_lift and idwt_obuf.
`timescale 1ns / 1ps

// Inverse 5/3 lifting along one image line. Each input item carries one
// low-pass and (except at the end of an odd-length line) one high-pass
// coefficient; the block returns reconstructed samples in line order, with
// line_done set on the last one. An item is registered on entry, the lifting
// step runs combinationally from that register into a three-entry result buffer,
// and the buffer drains one result per cycle while the receiver does not stall.
// A new item is taken while results still wait. Write hf_shift (index 0)
// and lf_prescale (index 1) only while no item is in flight.
module idwt53_horizontal_line (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  idwt_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output idwt_pkg::out_item_t out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i
);
  import idwt_pkg::*;

  logic [ShiftW-1:0] hf_shift_q, hf_shift_d;
  logic              lf_prescale_q, lf_prescale_d;

  in_item_t item_q;
  logic     item_valid_q, item_valid_d;
  logic     in_acc, fire, buf_free;
  res_set_t res;

  // Configuration is always writable; unknown indexes are dropped.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    hf_shift_d    = hf_shift_q;
    lf_prescale_d = lf_prescale_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgHfShift:    hf_shift_d    = cfg_data_i[ShiftW-1:0];
        CfgLfPrescale: lf_prescale_d = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Advance the registered item into the buffer once it has room; hold otherwise.
  assign fire       = item_valid_q & buf_free;
  assign in_stall_o = item_valid_q & ~fire;
  assign in_acc     = in_valid_i & ~in_stall_o;

  always_comb begin
    item_valid_d = item_valid_q;
    if (in_acc) begin
      item_valid_d = 1'b1;
    end else if (fire) begin
      item_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hf_shift_q    <= '0;
      lf_prescale_q <= 1'b0;
      item_valid_q  <= 1'b0;
    end else begin
      hf_shift_q    <= hf_shift_d;
      lf_prescale_q <= lf_prescale_d;
      item_valid_q  <= item_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q <= in_item_i;
    end
  end

  idwt_lift u_lift (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_i        (item_q),
    .fire_i        (fire),
    .hf_shift_i    (hf_shift_q),
    .lf_prescale_i (lf_prescale_q),
    .res_o         (res)
  );

  idwt_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (res),
    .load_i      (fire),
    .free_o      (buf_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

// File: hdl/idwt_lift.sv
// Lifting datapath: rebuilds even and odd samples from one registered item.
// Holds the previous even sample, previous shifted high-pass sample and line state.
// Depends on idwt_pkg.
`timescale 1ns / 1ps

module idwt_lift (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  idwt_pkg::in_item_t              item_i,
  input  logic                            fire_i,
  input  logic [idwt_pkg::ShiftW-1:0]     hf_shift_i,
  input  logic                            lf_prescale_i,
  output idwt_pkg::res_set_t              res_o
);
  import idwt_pkg::*;

  logic [SampleW-1:0] last_even_q, last_even_d;
  logic [SampleW-1:0] last_high_q, last_high_d;
  logic               mid_line_q, mid_line_d;

  logic [SampleW-1:0] hs, lv, even, odd, upd, pair;
  logic               hp, line_end;

  always_comb begin
    hp       = item_i.high_present;
    line_end = item_i.line_end | ~hp;
    hs = hp ? ({{(SampleW-HighW){item_i.high_sample[HighW-1]}}, item_i.high_sample}
               << hf_shift_i) : '0;
    lv = lf_prescale_i ? (item_i.low_sample << hf_shift_i) : item_i.low_sample;

    // Update term of the inverse update step; symmetric extension at either end.
    if (!mid_line_q) begin
      upd = SampleW'($signed(hs + SampleW'(1)) >>> 1);
    end else if (hp) begin
      upd = SampleW'($signed(last_high_q + hs + SampleW'(2)) >>> 2);
    end else begin
      upd = SampleW'($signed(last_high_q + SampleW'(1)) >>> 1);
    end
    even = lv - upd;
    pair = last_even_q + even;
    odd  = last_high_q + SampleW'($signed(pair) >>> 1);

    res_o = '0;
    if (!mid_line_q) begin
      res_o.res[0].pixel_value = even;
      res_o.res[0].line_done   = line_end & ~hp;
      res_o.res[1].pixel_value = hs + even;
      res_o.res[1].line_done   = 1'b1;
      res_o.count = (hp && line_end) ? CountW'(2) : CountW'(1);
    end else begin
      res_o.res[0].pixel_value = odd;
      res_o.res[0].line_done   = 1'b0;
      res_o.res[1].pixel_value = even;
      res_o.res[1].line_done   = line_end & ~hp;
      res_o.res[2].pixel_value = hs + even;
      res_o.res[2].line_done   = 1'b1;
      res_o.count = (hp && line_end) ? CountW'(3) : CountW'(2);
    end

    last_even_d = last_even_q;
    last_high_d = last_high_q;
    mid_line_d  = mid_line_q;
    if (fire_i) begin
      last_even_d = even;
      if (hp) begin
        last_high_d = hs;
      end
      mid_line_d = ~line_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_even_q <= '0;
      last_high_q <= '0;
      mid_line_q  <= 1'b0;
    end else begin
      last_even_q <= last_even_d;
      last_high_q <= last_high_d;
      mid_line_q  <= mid_line_d;
    end
  end

endmodule

// File: hdl/idwt_obuf.sv
// Result buffer: holds up to three results of one item and drains one per cycle unless stalled.
// Depends on idwt_pkg.
`timescale 1ns / 1ps

module idwt_obuf (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  idwt_pkg::res_set_t   res_i,
  input  logic                 load_i,
  output logic                 free_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output idwt_pkg::out_item_t  out_item_o
);
  import idwt_pkg::*;

  out_item_t [MaxRes-1:0] ent_q, ent_d;
  logic [CountW-1:0]      cnt_q, cnt_d;
  logic                   pop;

  assign out_valid_o = (cnt_q != '0);
  assign out_item_o  = ent_q[0];
  assign pop         = out_valid_o & ~out_stall_i;
  // Take a new bundle when empty or when the last result leaves this cycle.
  assign free_o      = (cnt_q == '0) || (cnt_q == CountW'(1) && pop);

  always_comb begin
    ent_d = ent_q;
    cnt_d = cnt_q;
    if (load_i) begin
      ent_d = res_i.res;
      cnt_d = res_i.count;
    end else if (pop) begin
      ent_d[0] = ent_q[1];
      ent_d[1] = ent_q[2];
      cnt_d    = cnt_q - CountW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

endmodule

// File: tb/idwt53_horizontal_line_tb.sv
// Self-checking testbench for idwt53_horizontal_line: drives line items, predicts the
// reconstructed samples in an inline lifting model and compares every result item.
// Depends on idwt_pkg and the idwt53_horizontal_line RTL.
`timescale 1ns / 1ps

module idwt53_horizontal_line_tb;
  import idwt_pkg::*;

  // Write to an index that holds no register; it must leave the settings alone.
  localparam logic [1:0] CfgSpare = 2'd3;
  localparam int unsigned IdlePct = 23;
  localparam int unsigned MaxReports = 10;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_item;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  // Predictor copy of the block's settings and line state.
  logic [ShiftW-1:0] shift_amt;
  logic              prescale_low;
  logic [31:0]       pred_even;
  logic [31:0]       prev_high;
  logic              in_line;

  out_item_t pending_pixels[$];
  bit        idle_en;
  int        fail_count;
  int        items_sent;
  int        lines_sent;
  int        pixels_checked;

  idwt53_horizontal_line dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  always #10 clk = ~clk;

  // Queue one expected sample.
  function automatic void push_pixel(logic [31:0] value, logic done);
    out_item_t r;
    r.pixel_value = value;
    r.line_done   = done;
    pending_pixels.push_back(r);
  endfunction

  // Inverse lifting step for one accepted item, with symmetric extension at both ends.
  function automatic void predict_samples(in_item_t it);
    logic [31:0] hs;
    logic [31:0] lv;
    logic [31:0] even;
    logic [31:0] odd;
    logic        last;
    hs   = it.high_present ? ({{16{it.high_sample[HighW-1]}}, it.high_sample} << shift_amt)
                           : 32'd0;
    lv   = prescale_low ? (32'(it.low_sample) << shift_amt) : 32'(it.low_sample);
    last = it.line_end || !it.high_present;
    if (!in_line) begin
      even = lv - 32'($signed(hs + 32'd1) >>> 1);
    end else begin
      if (it.high_present) begin
        even = lv - 32'($signed(prev_high + hs + 32'd2) >>> 2);
      end else begin
        // Odd-length close: mirror the previous high-pass sample.
        even = lv - 32'($signed(prev_high + 32'd1) >>> 1);
      end
      odd = prev_high + 32'($signed(pred_even + even) >>> 1);
      push_pixel(odd, 1'b0);
    end
    push_pixel(even, last && !it.high_present);
    if (it.high_present && last) push_pixel(hs + even, 1'b1);
    pred_even = even;
    if (it.high_present) prev_high = hs;
    in_line = !last;
    if (last) lines_sent++;
  endfunction

  // Hold the item until the block takes it; idle first at random.
  task automatic send_item(in_item_t it);
    @(negedge clk);
    while (idle_en && $urandom_range(99) < IdlePct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_samples(it);
    items_sent++;
  endtask

  // Drop valid and wait until every expected sample has come out.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CfgHfShift: begin
        shift_amt = value[ShiftW-1:0];
      end
      CfgLfPrescale: begin
        prescale_low = value[0];
      end
      default: begin
      end
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Unused upper data bits carry random junk.
  task automatic apply_setting(logic [ShiftW-1:0] shift, logic prescale);
    write_reg(CfgHfShift, ($urandom() & ~32'h1f) | 32'(shift));
    write_reg(CfgLfPrescale, ($urandom() & ~32'h1) | 32'(prescale));
  endtask

  function automatic in_item_t make_item(logic [31:0] low, logic [15:0] high, logic hp,
                                         logic last);
    in_item_t it;
    it.low_sample   = low;
    it.high_sample  = high;
    it.high_present = hp;
    it.line_end     = last;
    return it;
  endfunction

  function automatic logic [31:0] random_low();
    case ($urandom_range(3))
      0: return $urandom();
      1: return 32'($urandom_range(511)) - 32'd256;
      2: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return 32'($urandom_range(65535)) - 32'd32768;
    endcase
  endfunction

  // Reset settings: no shift, no low-pass prescale.
  task automatic test_reset_defaults();
    // Single-sample line: high missing on the first item, junk in the high field.
    send_item(make_item(32'd100, 16'h7fff, 1'b0, 1'b0));
    // Two-sample line closed by its first item.
    send_item(make_item(32'h7fff_ffff, 16'h7fff, 1'b1, 1'b1));
    // Four samples at the field extremes.
    send_item(make_item(32'h8000_0000, 16'h8000, 1'b1, 1'b0));
    send_item(make_item(32'h7fff_ffff, 16'h7fff, 1'b1, 1'b1));
    // Odd-length line.
    send_item(make_item(32'd5, 16'd7, 1'b1, 1'b0));
    send_item(make_item(-32'sd3, -16'sd9, 1'b1, 1'b0));
    send_item(make_item(32'd11, 16'h5a5a, 1'b0, 1'b1));
    // Missing high without line_end still closes the line; the next item starts fresh.
    send_item(make_item(32'd1, 16'd2, 1'b1, 1'b0));
    send_item(make_item(32'd3, 16'ha5a5, 1'b0, 1'b0));
    send_item(make_item(32'd4, 16'd5, 1'b1, 1'b1));
  endtask

  task automatic test_shift_extremes();
    apply_setting(5'd31, 1'b1);
    send_item(make_item(32'h7fff_ffff, 16'hffff, 1'b1, 1'b0));
    send_item(make_item(32'h8000_0000, 16'h7fff, 1'b1, 1'b0));
    send_item(make_item(32'hffff_ffff, 16'h8000, 1'b1, 1'b1));
    apply_setting(5'd16, 1'b0);
    send_item(make_item(32'h1234_5678, 16'h8001, 1'b1, 1'b0));
    send_item(make_item(32'hedcb_a987, 16'h7ffe, 1'b1, 1'b0));
    send_item(make_item(32'h0000_0001, 16'h0000, 1'b0, 1'b1));
    // A write to the spare index must change nothing.
    write_reg(CfgSpare, $urandom());
    send_item(make_item(32'd77, 16'h0101, 1'b1, 1'b1));
  endtask

  // Mostly well-formed lines; about one in ten is cut short by a missing high sample.
  task automatic send_random_line();
    int       len;
    int       cut;
    in_item_t it;
    len = ($urandom_range(9) == 0) ? $urandom_range(24, 12) : $urandom_range(8, 1);
    cut = ($urandom_range(9) == 0) ? $urandom_range(len - 1) : -1;
    for (int k = 0; k < len; k++) begin
      it = make_item(random_low(), 16'($urandom()), 1'b1, k == len - 1);
      if (it.line_end) it.high_present = 1'($urandom_range(1));
      if (k == cut) begin
        it.high_present = 1'b0;
        it.line_end     = 1'b0;
      end
      send_item(it);
    end
  endtask

  task automatic test_random_lines();
    int start;
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: apply_setting(5'd0, 1'b0);
        1: apply_setting(5'd16, 1'b0);
        2: apply_setting(5'd31, 1'b1);
        3: apply_setting(5'($urandom_range(31)), 1'($urandom_range(1)));
        4: apply_setting(5'd1, 1'b1);
        default: apply_setting(5'($urandom_range(16)), 1'b1);
      endcase
      // Phase four runs back to back on both sides.
      idle_en = (p != 4);
      start   = items_sent;
      while (items_sent - start < 25) send_random_line();
    end
    idle_en = 1'b1;
  endtask

  // Receiver stall, changed at the falling edge only.
  always @(negedge clk) begin
    out_stall <= idle_en && ($urandom_range(99) < IdlePct);
  end

  // Compare each accepted sample with the oldest expectation.
  always @(posedge clk) begin : check_pixels
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        fail_count++;
        if (fail_count <= MaxReports)
          $display("%0t: unexpected sample value=%h done=%b", $realtime,
                   out_item.pixel_value, out_item.line_done);
      end else begin
        want = pending_pixels.pop_front();
        pixels_checked++;
        if (out_item.pixel_value !== want.pixel_value ||
            out_item.line_done !== want.line_done) begin
          fail_count++;
          if (fail_count <= MaxReports)
            $display("%0t: sample %0d expected value=%h done=%b, got value=%h done=%b",
                     $realtime, pixels_checked, want.pixel_value, want.line_done,
                     out_item.pixel_value, out_item.line_done);
        end
      end
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_item      = '0;
    out_stall    = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    shift_amt    = '0;
    prescale_low = 1'b0;
    pred_even    = '0;
    prev_high    = '0;
    in_line      = 1'b0;
    idle_en      = 1'b1;
    fail_count   = 0;
    items_sent   = 0;
    lines_sent   = 0;
    pixels_checked = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_shift_extremes();
    test_random_lines();
    drain();

    $display("covered %0d items in %0d lines, %0d samples checked", items_sent, lines_sent,
             pixels_checked);
    $display("shifts 0 to 31, low-pass prescale on and off, random stalls on both sides");
    if (fail_count == 0 && pending_pixels.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("timeout with %0d samples outstanding", pending_pixels.size());
    $display("status: fail");
    $finish;
  end

endmodule

// File: sim.f
hdl/idwt_pkg.sv
hdl/idwt_lift.sv
hdl/idwt_obuf.sv
hdl/idwt53_horizontal_line.sv
tb/idwt53_horizontal_line_tb.sv
